>>> design/mtgt_pkg.sv
// ----------------------------------------------------------------------------
// mtgt_pkg
// Shared constants, types and digit helpers for the millisecond timestamp to
// GeneralizedTime formatter.
// ----------------------------------------------------------------------------
package mtgt_pkg;

   localparam int NSTG = 13;

   typedef logic [NSTG-1:0] mtgt_stage_type;

   localparam logic [47:0] MAX_MS = 48'd253402300799999;

   // milliseconds per day over 1024
   localparam logic [16:0] DAY_MS_HI = 17'd84375;
   localparam logic [21:0] DAY_RCP   = 22'((64'd1 << 38) / 64'd84375);

   localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
   localparam logic [24:0] SEC_RCP     = 25'(((64'd1 << 31) + 64'd124) / 64'd125);
   localparam logic [11:0] SEC_PER_HR  = 12'd3600;
   localparam logic [13:0] HR_RCP      = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
   localparam logic [5:0]  SEC_PER_MIN = 6'd60;
   localparam logic [10:0] MIN_RCP     = 11'(((64'd1 << 14) + 64'd14) / 64'd15);
   localparam logic [10:0] MS_RCP100   = 11'(((64'd1 << 17) + 64'd99) / 64'd100);

   localparam logic [21:0] EPOCH_DAYS   = 22'd719468;
   localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
   localparam logic [17:0] DOE_LAST     = 18'd146096;
   localparam logic [22:0] ERA_RCP      = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
   localparam logic [18:0] RCP_1460     = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
   localparam logic [18:0] RCP_36524    = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
   localparam logic [18:0] RCP_365      = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam logic [9:0]  RCP_YOE100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
   localparam logic [11:0] RCP_153      = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
   localparam logic [11:0] RCP_5        = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
   localparam logic [14:0] RCP_Y1000    = 15'(((64'd1 << 24) + 64'd999) / 64'd1000);
   localparam logic [14:0] RCP_Y100     = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
   localparam logic [14:0] RCP_Y10      = 15'(((64'd1 << 18) + 64'd9) / 64'd10);
   localparam logic [7:0]  RCP_10       = 8'(((64'd1 << 11) + 64'd9) / 64'd10);

   localparam logic [7:0] ASCII_ZERO = 8'd48;
   localparam logic [7:0] ASCII_DOT  = 8'h2E;
   localparam logic [7:0] ASCII_Z    = 8'h5A;
   localparam logic [7:0] ASCII_NUL  = 8'h00;

   typedef struct packed {
      logic [4:0] hh;
      logic [5:0] mi;
      logic [5:0] ss;
      logic [3:0] msh;
      logic [6:0] msr;
   } tod_type;

   typedef struct packed {
      logic [3:0] yth;
      logic [3:0] yhu;
      logic [3:0] yte;
      logic [3:0] yun;
      logic [3:0] mo;
      logic [4:0] day;
   } date_type;

   function automatic logic [7:0] ascii_digit(input logic [3:0] d);
      return ASCII_ZERO + 8'(d);
   endfunction

   // two decimal digits of a value below 100
   function automatic logic [15:0] two_digits(input logic [6:0] v);
      logic [14:0] p;
      logic [3:0]  tens;
      logic [6:0]  units;
      p     = 15'(v) * 15'(RCP_10);
      tens  = p[14:11];
      units = v - 7'(tens) * 7'd10;
      return {ascii_digit(tens), ascii_digit(units[3:0])};
   endfunction

endpackage

>>> design/mtgt_split.sv
// ----------------------------------------------------------------------------
// mtgt_split
// Stages 0 to 2: splits milliseconds into whole days and milliseconds of day
// by reciprocal estimate and one correction, and flags out-of-range input.
// ----------------------------------------------------------------------------
module mtgt_split (
   input  logic                    clock,
   input  mtgt_pkg::mtgt_stage_type load,
   input  logic [47:0]             ms,
   output logic [21:0]             days,
   output logic [26:0]             msod,
   output logic                    ovf
);
   import mtgt_pkg::*;

   logic [53:0] est_p;
   logic [21:0] qe_in;
   logic        ovf_in;
   logic [21:0] qe0_ff;
   logic [47:0] ms0_ff;
   logic        ovf0_ff;

   logic [38:0] prod_in;
   logic [38:0] prod1_ff;
   logic [21:0] qe1_ff;
   logic [47:0] ms1_ff;
   logic        ovf1_ff;

   logic [37:0] rem;
   logic [17:0] rlo;
   logic [17:0] rfix;
   logic [21:0] days_in;
   logic [26:0] msod_in;
   logic [21:0] days_ff;
   logic [26:0] msod_ff;
   logic        ovf2_ff;

   always_comb begin
      est_p  = 54'(ms[47:16]) * 54'(DAY_RCP);
      qe_in  = est_p[53:32];
      ovf_in = ms > MAX_MS;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         qe0_ff  <= qe_in;
         ms0_ff  <= ms;
         ovf0_ff <= ovf_in;
      end
   end

   assign prod_in = 39'(qe0_ff) * 39'(DAY_MS_HI);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         prod1_ff <= prod_in;
         qe1_ff   <= qe0_ff;
         ms1_ff   <= ms0_ff;
         ovf1_ff  <= ovf0_ff;
      end
   end

   always_comb begin
      rem  = ms1_ff[47:10] - prod1_ff[37:0];
      rlo  = rem[17:0];
      rfix = rlo - 18'(DAY_MS_HI);
      if (rlo >= 18'(DAY_MS_HI)) begin
         days_in = qe1_ff + 22'd1;
         msod_in = {rfix[16:0], ms1_ff[9:0]};
      end else begin
         days_in = qe1_ff;
         msod_in = {rlo[16:0], ms1_ff[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         days_ff <= days_in;
         msod_ff <= msod_in;
         ovf2_ff <= ovf1_ff;
      end
   end

   assign days = days_ff;
   assign msod = msod_ff;
   assign ovf  = ovf2_ff;

endmodule

>>> design/mtgt_tod.sv
// ----------------------------------------------------------------------------
// mtgt_tod
// Stages 3 to 11: time of day into hours, minutes, seconds and millisecond
// digits, then delayed to line up with the date path.
// ----------------------------------------------------------------------------
module mtgt_tod (
   input  logic                    clock,
   input  mtgt_pkg::mtgt_stage_type load,
   input  logic [26:0]             msod,
   output mtgt_pkg::tod_type       tod
);
   import mtgt_pkg::*;

   logic [48:0] sec_p;
   logic [16:0] secs3_ff;
   logic [26:0] msod3_ff;

   logic [26:0] msec_d;
   logic [26:0] hh_p;
   logic [9:0]  msec4_ff;
   logic [4:0]  hh4_ff;
   logic [16:0] secs4_ff;

   logic [16:0] rem_d;
   logic [20:0] msh_p;
   logic [11:0] rem5_ff;
   logic [3:0]  msh5_ff;
   logic [9:0]  msec5_ff;
   logic [4:0]  hh5_ff;

   logic [20:0] mi_p;
   logic [9:0]  msr_d;
   logic [5:0]  mi6_ff;
   logic [6:0]  msr6_ff;
   logic [11:0] rem6_ff;
   logic [4:0]  hh6_ff;
   logic [3:0]  msh6_ff;

   logic [11:0] ss_d;
   tod_type     dly_in [7:11];
   tod_type     dly_ff [7:11];

   assign sec_p = 49'(msod[26:3]) * 49'(SEC_RCP);

   always_ff @(posedge clock) begin
      if (load[3]) begin
         secs3_ff <= sec_p[47:31];
         msod3_ff <= msod;
      end
   end

   always_comb begin
      msec_d = msod3_ff - 27'(secs3_ff) * 27'(MS_PER_SEC);
      hh_p   = 27'(secs3_ff[16:4]) * 27'(HR_RCP);
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         msec4_ff <= msec_d[9:0];
         hh4_ff   <= hh_p[25:21];
         secs4_ff <= secs3_ff;
      end
   end

   always_comb begin
      rem_d = secs4_ff - 17'(hh4_ff) * 17'(SEC_PER_HR);
      msh_p = 21'(msec4_ff) * 21'(MS_RCP100);
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         rem5_ff  <= rem_d[11:0];
         msh5_ff  <= msh_p[20:17];
         msec5_ff <= msec4_ff;
         hh5_ff   <= hh4_ff;
      end
   end

   always_comb begin
      mi_p  = 21'(rem5_ff[11:2]) * 21'(MIN_RCP);
      msr_d = msec5_ff - 10'(msh5_ff) * 10'd100;
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         mi6_ff  <= mi_p[19:14];
         msr6_ff <= msr_d[6:0];
         rem6_ff <= rem5_ff;
         hh6_ff  <= hh5_ff;
         msh6_ff <= msh5_ff;
      end
   end

   // alignment delay up to the last calculation stage
   always_comb begin
      ss_d          = rem6_ff - 12'(mi6_ff) * 12'(SEC_PER_MIN);
      dly_in[7].hh  = hh6_ff;
      dly_in[7].mi  = mi6_ff;
      dly_in[7].ss  = ss_d[5:0];
      dly_in[7].msh = msh6_ff;
      dly_in[7].msr = msr6_ff;
      for (int i = 8; i <= 11; i++) begin
         dly_in[i] = dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 7; i <= 11; i++) begin
         if (load[i]) begin
            dly_ff[i] <= dly_in[i];
         end
      end
   end

   assign tod = dly_ff[11];

endmodule

>>> design/mtgt_date.sv
// ----------------------------------------------------------------------------
// mtgt_date
// Stages 3 to 11: day count to proleptic Gregorian year, month and day using
// 400-year eras counted from 0000-03-01, then year digits.
// ----------------------------------------------------------------------------
module mtgt_date (
   input  logic                    clock,
   input  mtgt_pkg::mtgt_stage_type load,
   input  logic [21:0]             days,
   output mtgt_pkg::date_type      date
);
   import mtgt_pkg::*;

   logic [21:0] z_d;
   logic [44:0] era_p;
   logic [21:0] z3_ff;
   logic [4:0]  era3_ff;

   logic [21:0] doe_d;
   logic [17:0] doe4_ff;
   logic [4:0]  era4_ff;

   logic [36:0] pa;
   logic [36:0] pb;
   logic [17:0] t_d;
   logic [17:0] t5_ff;
   logic [17:0] doe5_ff;
   logic [4:0]  era5_ff;

   logic [36:0] py;
   logic [8:0]  yoe6_ff;
   logic [17:0] doe6_ff;
   logic [4:0]  era6_ff;

   logic [18:0] pc;
   logic [17:0] base_d;
   logic [17:0] doy_d;
   logic [13:0] y_d;
   logic [8:0]  doy7_ff;
   logic [13:0] y7_ff;

   logic [10:0] v_d;
   logic [22:0] pm;
   logic [3:0]  mp8_ff;
   logic [8:0]  doy8_ff;
   logic [13:0] y8_ff;

   logic [10:0] w_d;
   logic [22:0] pd;
   logic        late;
   logic [3:0]  mo_d;
   logic [8:0]  dd9_ff;
   logic [3:0]  mo9_ff;
   logic [8:0]  doy9_ff;
   logic [13:0] y9_ff;

   logic [8:0]  day_d;
   logic [28:0] p1000;
   logic [28:0] p100;
   logic [28:0] p10;
   logic [4:0]  day10_ff;
   logic [3:0]  mo10_ff;
   logic [3:0]  q1000_ff;
   logic [6:0]  q100_ff;
   logic [10:0] q10_ff;
   logic [13:0] y10_ff;

   logic [6:0]  hu_d;
   logic [10:0] te_d;
   logic [13:0] un_d;
   date_type    date_in;
   date_type    date_ff;

   always_comb begin
      z_d   = days + EPOCH_DAYS;
      era_p = 45'(z_d) * 45'(ERA_RCP);
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         z3_ff   <= z_d;
         era3_ff <= era_p[44:40];
      end
   end

   assign doe_d = z3_ff - 22'(era3_ff) * 22'(DAYS_PER_ERA);

   always_ff @(posedge clock) begin
      if (load[4]) begin
         doe4_ff <= doe_d[17:0];
         era4_ff <= era3_ff;
      end
   end

   // day of era less the leap days before it
   always_comb begin
      pa  = 37'(doe4_ff) * 37'(RCP_1460);
      pb  = 37'(doe4_ff) * 37'(RCP_36524);
      t_d = doe4_ff - 18'(pa[35:29]) + 18'(pb[36:34]) - 18'(doe4_ff == DOE_LAST);
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         t5_ff   <= t_d;
         doe5_ff <= doe4_ff;
         era5_ff <= era4_ff;
      end
   end

   assign py = 37'(t5_ff) * 37'(RCP_365);

   always_ff @(posedge clock) begin
      if (load[6]) begin
         yoe6_ff <= py[35:27];
         doe6_ff <= doe5_ff;
         era6_ff <= era5_ff;
      end
   end

   always_comb begin
      pc     = 19'(yoe6_ff) * 19'(RCP_YOE100);
      base_d = 18'(yoe6_ff) * 18'd365 + 18'(yoe6_ff[8:2]) - 18'(pc[18:16]);
      doy_d  = doe6_ff - base_d;
      y_d    = 14'(yoe6_ff) + 14'(era6_ff) * 14'd400;
   end

   always_ff @(posedge clock) begin
      if (load[7]) begin
         doy7_ff <= doy_d[8:0];
         y7_ff   <= y_d;
      end
   end

   always_comb begin
      v_d = 11'(doy7_ff) * 11'd5 + 11'd2;
      pm  = 23'(v_d) * 23'(RCP_153);
   end

   always_ff @(posedge clock) begin
      if (load[8]) begin
         mp8_ff  <= pm[22:19];
         doy8_ff <= doy7_ff;
         y8_ff   <= y7_ff;
      end
   end

   // january and february belong to the next calendar year
   always_comb begin
      w_d  = 11'(mp8_ff) * 11'd153 + 11'd2;
      pd   = 23'(w_d) * 23'(RCP_5);
      late = mp8_ff >= 4'd10;
      mo_d = late ? mp8_ff - 4'd9 : mp8_ff + 4'd3;
   end

   always_ff @(posedge clock) begin
      if (load[9]) begin
         dd9_ff  <= pd[22:14];
         mo9_ff  <= mo_d;
         doy9_ff <= doy8_ff;
         y9_ff   <= y8_ff + 14'(late);
      end
   end

   always_comb begin
      day_d = doy9_ff - dd9_ff + 9'd1;
      p1000 = 29'(y9_ff) * 29'(RCP_Y1000);
      p100  = 29'(y9_ff) * 29'(RCP_Y100);
      p10   = 29'(y9_ff) * 29'(RCP_Y10);
   end

   always_ff @(posedge clock) begin
      if (load[10]) begin
         day10_ff <= day_d[4:0];
         mo10_ff  <= mo9_ff;
         q1000_ff <= p1000[27:24];
         q100_ff  <= p100[27:21];
         q10_ff   <= p10[28:18];
         y10_ff   <= y9_ff;
      end
   end

   always_comb begin
      hu_d        = q100_ff - 7'(q1000_ff) * 7'd10;
      te_d        = q10_ff - 11'(q100_ff) * 11'd10;
      un_d        = y10_ff - 14'(q10_ff) * 14'd10;
      date_in.yth = q1000_ff;
      date_in.yhu = hu_d[3:0];
      date_in.yte = te_d[3:0];
      date_in.yun = un_d[3:0];
      date_in.mo  = mo10_ff;
      date_in.day = day10_ff;
   end

   always_ff @(posedge clock) begin
      if (load[11]) begin
         date_ff <= date_in;
      end
   end

   assign date = date_ff;

endmodule

>>> design/ms_time_to_generalized_time.sv
// ----------------------------------------------------------------------------
// ms_time_to_generalized_time
// Unix millisecond timestamp to GeneralizedTime text YYYYMMDDhhmmss.fffZ.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle while the output is not stalled and returns
// one result beat per input beat, in order. A beat passes through 13 register
// stages: three split the count into days and milliseconds of day, nine run
// the calendar and time-of-day arithmetic (up to three constant-reciprocal
// multiplies each), and the last stage is the output register. Each stage
// advances on its own when the stage after it is empty or moving, so a stall
// on rsp_ready fills the bubbles before req_ready drops. Inputs later than
// 9999-12-31T23:59:59.999 give rsp_out_of_range high and all-zero text.
module ms_time_to_generalized_time (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [47:0] req_ms_since_epoch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_text_first,
   output logic [63:0] rsp_text_middle,
   output logic [31:0] rsp_text_last,
   output logic        rsp_out_of_range
);
   import mtgt_pkg::*;

   mtgt_stage_type load;
   logic [NSTG-1:0] valid_in;
   logic [NSTG-1:0] valid_ff;

   logic [21:0] days;
   logic [26:0] msod;
   logic        ovf_split;
   tod_type     tod;
   date_type    date;

   logic        ovf_in [3:11];
   logic        ovf_ff [3:11];

   logic [63:0] first_in;
   logic [63:0] middle_in;
   logic [31:0] last_in;
   logic [63:0] first_ff;
   logic [63:0] middle_ff;
   logic [31:0] last_ff;
   logic        ovf_out_ff;

   // stage advance chain from the output back to the input
   always_comb begin
      load[NSTG-1] = ~valid_ff[NSTG-1] | rsp_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         load[i] = ~valid_ff[i] | load[i+1];
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   mtgt_split u_split (
      .clock (clock),
      .load  (load),
      .ms    (req_ms_since_epoch),
      .days  (days),
      .msod  (msod),
      .ovf   (ovf_split)
   );

   mtgt_tod u_tod (
      .clock (clock),
      .load  (load),
      .msod  (msod),
      .tod   (tod)
   );

   mtgt_date u_date (
      .clock (clock),
      .load  (load),
      .days  (days),
      .date  (date)
   );

   always_comb begin
      ovf_in[3] = ovf_split;
      for (int i = 4; i <= 11; i++) begin
         ovf_in[i] = ovf_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 3; i <= 11; i++) begin
         if (load[i]) begin
            ovf_ff[i] <= ovf_in[i];
         end
      end
   end

   // text assembly
   always_comb begin
      if (ovf_ff[11]) begin
         first_in  = '0;
         middle_in = '0;
         last_in   = '0;
      end else begin
         first_in  = {ascii_digit(date.yth), ascii_digit(date.yhu),
                      ascii_digit(date.yte), ascii_digit(date.yun),
                      two_digits(7'(date.mo)), two_digits(7'(date.day))};
         middle_in = {two_digits(7'(tod.hh)), two_digits(7'(tod.mi)),
                      two_digits(7'(tod.ss)), ASCII_DOT, ascii_digit(tod.msh)};
         last_in   = {two_digits(tod.msr), ASCII_Z, ASCII_NUL};
      end
   end

   always_ff @(posedge clock) begin
      if (load[NSTG-1]) begin
         first_ff   <= first_in;
         middle_ff  <= middle_in;
         last_ff    <= last_in;
         ovf_out_ff <= ovf_ff[11];
      end
   end

   assign req_ready        = load[0];
   assign rsp_valid        = valid_ff[NSTG-1];
   assign rsp_text_first   = first_ff;
   assign rsp_text_middle  = middle_ff;
   assign rsp_text_last    = last_ff;
   assign rsp_out_of_range = ovf_out_ff;

   a_ovf_text_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         rsp_text_first == '0 && rsp_text_middle == '0 && rsp_text_last == '0)
      else $error("out-of-range beat carries text");

   a_month_tens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |->
         rsp_text_first[31:24] == ASCII_ZERO || rsp_text_first[31:24] == ASCII_ZERO + 8'd1)
      else $error("month tens digit out of range");

   a_hour_tens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |->
         rsp_text_middle[63:56] >= ASCII_ZERO && rsp_text_middle[63:56] <= ASCII_ZERO + 8'd2)
      else $error("hour tens digit out of range");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat straight after reset");

endmodule
